// ===== hdl/ptws_pkg.sv =====
`timescale 1ns / 1ps
// ptws_pkg: shared types, constants and helpers of the procedural wall texel sampler
package ptws_pkg;

  localparam logic [2:0] KIND_FLOOR  = 3'd0;
  localparam logic [2:0] KIND_BURROW = 3'd1;
  localparam logic [2:0] KIND_PANTRY = 3'd2;
  localparam logic [2:0] KIND_CELLAR = 3'd3;
  localparam logic [2:0] KIND_BASKET = 3'd4;

  localparam int PIPE_LAT = 8;

  localparam logic [31:0] HASH_MUL_X = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL_Y = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

  localparam logic [31:0] SEED_EARTH = 32'h19a7c35d;
  localparam logic [31:0] SEED_GROUT = 32'h48f1a2c3;
  localparam logic [31:0] SEED_TILE  = 32'hb5297a4d;
  localparam logic [31:0] SEED_BRICK = 32'h6d2b79f5;
  localparam logic [31:0] SEED_GRAIN = 32'h27d4eb2f;
  localparam logic [31:0] SEED_WEAVE = 32'ha24baed4;

  localparam logic [7:0] DIV12_MUL   = 8'd171;
  localparam int         DIV12_SHIFT = 11;
  localparam logic [6:0] DIV3_MUL    = 7'd43;
  localparam int         DIV3_SHIFT  = 7;

  typedef logic signed [10:0] chan_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t RGB_FLOOR  = '{r: 8'd70,  g: 8'd52,  b: 8'd38};
  localparam rgb_t RGB_BURROW = '{r: 8'd112, g: 8'd72,  b: 8'd44};
  localparam rgb_t RGB_PANTRY = '{r: 8'd196, g: 8'd184, b: 8'd148};
  localparam rgb_t RGB_CELLAR = '{r: 8'd88,  g: 8'd96,  b: 8'd104};
  localparam rgb_t RGB_BASKET = '{r: 8'd164, g: 8'd112, b: 8'd52};
  localparam rgb_t RGB_BAD    = '{r: 8'd255, g: 8'd0,   b: 8'd255};

  localparam chan_t WEAVE_PROFILE [4] = '{-11'sd18, 11'sd18, 11'sd9, -11'sd11};

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       en;
  } ctl_t;

  typedef struct packed {
    logic       grout;
    logic       edge_hl;
    logic       mortar;
    logic       over;
    logic [1:0] pos;
  } pat_t;

  function automatic logic [31:0] mod_inv(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  localparam logic [23:0] INV53 = 24'(mod_inv(32'd53));
  localparam logic [23:0] LIM53 = 24'((2 ** 24 - 1) / 53);
  localparam logic [15:0] INV79 = 16'(mod_inv(32'd79));
  localparam logic [15:0] LIM79 = 16'((2 ** 16 - 1) / 79);

  function automatic logic signed [7:0] div3(input logic signed [7:0] a);
    logic [7:0]  mag;
    logic [14:0] prod;
    logic [7:0]  q;
    mag  = a[7] ? 8'(-a) : 8'(a);
    prod = 15'(mag) * 15'(DIV3_MUL);
    q    = 8'(prod >> DIV3_SHIFT);
    return a[7] ? 8'(-q) : q;
  endfunction

  function automatic logic [7:0] clamp8(input chan_t v);
    logic [7:0] c;
    if (v < 11'sd0) begin
      c = 8'd0;
    end else if (v > 11'sd255) begin
      c = 8'd255;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

endpackage

// ===== hdl/procedural_wall_texel_sampler.sv =====
`timescale 1ns / 1ps
// procedural_wall_texel_sampler: top level of the procedural wall texel sampler
//
//   channel  handshake              payload
//   input    start, busy            in_tile_kind, in_tex_x, in_tex_y
//   result   out_valid (strobe)     out_red, out_green, out_blue
//   config   cfg_valid, cfg_ready   cfg_patterns_enabled
//
// One texel per clock; each beat's result strobes out_valid as it leaves the pipeline.
// Stages: two wrap stages, one geometry stage, three hash stages (two chained
// 32x32 multiplies), two shading stages.
// Synchronous reset flushes all valid bits and clears patterns_enabled; busy
// stays high for the first cycle after reset and low from then on.
// No stalls on either side: results are never held off.
module procedural_wall_texel_sampler
  import ptws_pkg::*;
#(
  parameter int TEX_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_tile_kind,
  input  logic signed [15:0] in_tex_x,
  input  logic signed [15:0] in_tex_y,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_patterns_enabled
);

  localparam int CW = $clog2(TEX_SIZE);
  localparam int HW = CW + 1;

  logic          busy_r, en_r;
  ctl_t          in_ctl, wrap_ctl, geo_ctl;
  logic [CW-1:0] wx, wy;
  pat_t          geo_pat;
  logic [HW-1:0] ha_x, ha_y, hb_x, hb_y;
  logic [31:0]   ha_seed, na, nb;
  ctl_t          dly_ctl_r [3];
  pat_t          dly_pat_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      en_r   <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        en_r <= cfg_patterns_enabled;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  always_comb begin
    in_ctl.valid = start && !busy_r;
    in_ctl.kind  = in_tile_kind;
    in_ctl.en    = en_r;
  end

  ptws_wrap #(.TEX_SIZE(TEX_SIZE)) u_wrap (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (in_ctl),
    .in_x    (in_tex_x),
    .in_y    (in_tex_y),
    .out_ctl (wrap_ctl),
    .out_x   (wx),
    .out_y   (wy)
  );

  ptws_geom #(.TEX_SIZE(TEX_SIZE)) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (wrap_ctl),
    .in_x    (wx),
    .in_y    (wy),
    .out_ctl (geo_ctl),
    .out_pat (geo_pat),
    .ha_x    (ha_x),
    .ha_y    (ha_y),
    .ha_seed (ha_seed),
    .hb_x    (hb_x),
    .hb_y    (hb_y)
  );

  ptws_hash #(.IN_W(HW)) u_hash_a (
    .clk  (clk),
    .hx   (ha_x),
    .hy   (ha_y),
    .seed (ha_seed),
    .h    (na)
  );

  ptws_hash #(.IN_W(HW)) u_hash_b (
    .clk  (clk),
    .hx   (hb_x),
    .hy   (hb_y),
    .seed (SEED_GRAIN),
    .h    (nb)
  );

  // hold control and pattern bits alongside the hash stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        dly_ctl_r[i].valid <= 1'b0;
      end
    end else begin
      dly_ctl_r[0] <= geo_ctl;
      dly_ctl_r[1] <= dly_ctl_r[0];
      dly_ctl_r[2] <= dly_ctl_r[1];
    end
  end

  always_ff @(posedge clk) begin
    dly_pat_r[0] <= geo_pat;
    dly_pat_r[1] <= dly_pat_r[0];
    dly_pat_r[2] <= dly_pat_r[1];
  end

  ptws_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (dly_ctl_r[2]),
    .in_pat    (dly_pat_r[2]),
    .na        (na),
    .nb        (nb),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// ===== hdl/ptws_wrap.sv =====
`timescale 1ns / 1ps
// ptws_wrap: two-stage wrap of both signed coordinates into 0..TEX_SIZE-1
module ptws_wrap
  import ptws_pkg::*;
#(
  parameter int TEX_SIZE = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctl_t                         in_ctl,
  input  logic signed [15:0]           in_x,
  input  logic signed [15:0]           in_y,
  output ctl_t                         out_ctl,
  output logic [$clog2(TEX_SIZE)-1:0]  out_x,
  output logic [$clog2(TEX_SIZE)-1:0]  out_y
);

  localparam int CW   = $clog2(TEX_SIZE);
  localparam int BIAS = TEX_SIZE * ((32768 + TEX_SIZE - 1) / TEX_SIZE);
  localparam int UW   = $clog2(32768 + BIAS);
  localparam int RW   = 33 - CW;
  localparam int PW   = UW + RW;
  localparam int QW   = PW - 32;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << 32) + 64'(TEX_SIZE - 1)) / 64'(TEX_SIZE));

  logic [UW-1:0] ux_nxt, uy_nxt, ux_r, uy_r;
  logic [PW-1:0] px, py;
  logic [QW-1:0] qx_nxt, qy_nxt, qx_r, qy_r;
  logic [UW-1:0] rx, ry;
  logic [CW-1:0] wx_nxt, wy_nxt, wx_r, wy_r;
  ctl_t          c1_r, c2_r;

  always_comb begin
    ux_nxt = UW'(int'(in_x) + BIAS);
    uy_nxt = UW'(int'(in_y) + BIAS);
    px     = PW'(ux_nxt) * PW'(RECIP);
    py     = PW'(uy_nxt) * PW'(RECIP);
    qx_nxt = px[PW-1:32];
    qy_nxt = py[PW-1:32];
  end

  always_comb begin
    rx     = ux_r - UW'(UW'(qx_r) * UW'(TEX_SIZE));
    ry     = uy_r - UW'(UW'(qy_r) * UW'(TEX_SIZE));
    wx_nxt = rx[CW-1:0];
    wy_nxt = ry[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
    end else begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    ux_r <= ux_nxt;
    uy_r <= uy_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
  end

  assign out_ctl = c2_r;
  assign out_x   = wx_r;
  assign out_y   = wy_r;

endmodule

// ===== hdl/ptws_geom.sv =====
`timescale 1ns / 1ps
// ptws_geom: pattern geometry and hash operand selection for each wall kind
module ptws_geom
  import ptws_pkg::*;
#(
  parameter int TEX_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctl_t                        in_ctl,
  input  logic [$clog2(TEX_SIZE)-1:0] in_x,
  input  logic [$clog2(TEX_SIZE)-1:0] in_y,
  output ctl_t                        out_ctl,
  output pat_t                        out_pat,
  output logic [$clog2(TEX_SIZE):0]   ha_x,
  output logic [$clog2(TEX_SIZE):0]   ha_y,
  output logic [31:0]                 ha_seed,
  output logic [$clog2(TEX_SIZE):0]   hb_x,
  output logic [$clog2(TEX_SIZE):0]   hb_y
);

  localparam int CW = $clog2(TEX_SIZE);
  localparam int HW = CW + 1;

  logic [CW+7:0] rprod;
  logic [CW-4:0] row;
  logic [CW-1:0] yr;
  logic [HW-1:0] xo, col;
  pat_t          pat_nxt, pat_r;
  logic [HW-1:0] hax_nxt, hay_nxt, hax_r, hay_r, hbx_r, hby_r;
  logic [31:0]   seed_nxt, seed_r;
  ctl_t          ctl_r;

  always_comb begin
    rprod = (CW + 8)'(in_y) * (CW + 8)'(DIV12_MUL);
    row   = rprod[CW+7:DIV12_SHIFT];
    yr    = in_y - CW'({row, 3'b000}) - CW'({row, 2'b00});
    xo    = HW'(in_x) + (row[0] ? HW'(8) : HW'(0));
    col   = xo >> 4;

    pat_nxt.grout   = (in_x[3:1] == 3'd0) || (in_y[3:1] == 3'd0);
    pat_nxt.edge_hl = (in_x[3:0] == 4'd2) || (in_y[3:0] == 4'd2);
    pat_nxt.mortar  = (xo[3:1] == 3'd0) || (yr < CW'(2));
    pat_nxt.over    = ~(in_x[2] ^ in_y[2]);
    pat_nxt.pos     = pat_nxt.over ? in_x[1:0] : in_y[1:0];

    case (in_ctl.kind)
      KIND_BURROW: begin
        hax_nxt  = HW'(in_x);
        hay_nxt  = HW'(in_y);
        seed_nxt = SEED_EARTH;
      end
      KIND_PANTRY: begin
        if (pat_nxt.grout) begin
          hax_nxt  = HW'(in_x);
          hay_nxt  = HW'(in_y);
          seed_nxt = SEED_GROUT;
        end else begin
          hax_nxt  = HW'(in_x >> 4);
          hay_nxt  = HW'(in_y >> 4);
          seed_nxt = SEED_TILE;
        end
      end
      KIND_CELLAR: begin
        hax_nxt  = col;
        hay_nxt  = HW'(row);
        seed_nxt = SEED_BRICK;
      end
      KIND_BASKET: begin
        hax_nxt  = HW'(in_x);
        hay_nxt  = HW'(in_y);
        seed_nxt = SEED_WEAVE;
      end
      default: begin
        hax_nxt  = HW'(in_x);
        hay_nxt  = HW'(in_y);
        seed_nxt = SEED_EARTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    hax_r  <= hax_nxt;
    hay_r  <= hay_nxt;
    seed_r <= seed_nxt;
    hbx_r  <= HW'(in_x);
    hby_r  <= HW'(in_y);
  end

  assign out_ctl = ctl_r;
  assign out_pat = pat_r;
  assign ha_x    = hax_r;
  assign ha_y    = hay_r;
  assign ha_seed = seed_r;
  assign hb_x    = hbx_r;
  assign hb_y    = hby_r;

endmodule

// ===== hdl/ptws_hash.sv =====
`timescale 1ns / 1ps
// ptws_hash: three-stage pipelined 32-bit coordinate hash
module ptws_hash
  import ptws_pkg::*;
#(
  parameter int IN_W = 7
) (
  input  logic            clk,
  input  logic [IN_W-1:0] hx,
  input  logic [IN_W-1:0] hy,
  input  logic [31:0]     seed,
  output logic [31:0]     h
);

  logic [31:0] mx, my, t1, t2;
  logic [31:0] h1_nxt, h2_nxt, h3_nxt;
  logic [31:0] h1_r, h2_r, h3_r;

  always_comb begin
    mx     = 32'(hx) * HASH_MUL_X;
    my     = 32'(hy) * HASH_MUL_Y;
    t1     = mx ^ my ^ seed;
    h1_nxt = t1 ^ (t1 >> 16);
    h2_nxt = h1_r * HASH_MUL_A;
    t2     = h2_r ^ (h2_r >> 15);
    h3_nxt = t2 * HASH_MUL_B;
  end

  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    h3_r <= h3_nxt;
  end

  assign h = h3_r ^ (h3_r >> 16);

endmodule

// ===== hdl/ptws_shade.sv =====
`timescale 1ns / 1ps
// ptws_shade: two-stage color build, speck test, fallback select and clamp
module ptws_shade
  import ptws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        in_ctl,
  input  pat_t        in_pat,
  input  logic [31:0] na,
  input  logic [31:0] nb,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  chan_t       ev, gv, tv, ee, tone, bg, bs, wl;
  logic [23:0] m53;
  logic [15:0] m79;
  chan_t       r_nxt, g_nxt, b_nxt, r7_r, g7_r, b7_r;
  logic        dark_nxt, light_nxt, dark7_r, light7_r;
  ctl_t        ctl7_r;
  chan_t       ar, ag, ab;
  rgb_t        shaded, rgb_nxt, rgb_r;
  logic        valid_r;

  always_comb begin
    ev   = $signed({6'd0, na[4:0]}) - 11'sd15;
    gv   = $signed({8'd0, na[2:0]});
    tv   = $signed({7'd0, na[3:0]}) - 11'sd7;
    ee   = in_pat.edge_hl ? 11'sd9 : 11'sd0;
    tone = $signed({6'd0, na[4:0]}) - 11'sd15;
    bg   = $signed({8'd0, nb[2:0]}) - 11'sd3;
    bs   = tone + bg;
    wl   = WEAVE_PROFILE[in_pat.pos] + $signed({8'd0, na[2:0]}) - 11'sd3
           - (in_pat.over ? 11'sd0 : 11'sd8);
    m53  = 24'(na[31:8] * INV53);
    m79  = 16'(na[31:16] * INV79);

    case (in_ctl.kind)
      KIND_BURROW: begin
        r_nxt = 11'sd112 + ev;
        g_nxt = 11'sd70 + chan_t'(div3(8'(ev <<< 1)));
        b_nxt = 11'sd40 + chan_t'(div3(8'(ev)));
      end
      KIND_PANTRY: begin
        if (in_pat.grout) begin
          r_nxt = 11'sd101 + gv;
          g_nxt = 11'sd108 + gv;
          b_nxt = 11'sd108 + gv;
        end else begin
          r_nxt = 11'sd207 + tv + ee;
          g_nxt = 11'sd201 + tv + ee;
          b_nxt = 11'sd169 + tv + ee;
        end
      end
      KIND_CELLAR: begin
        if (in_pat.mortar) begin
          r_nxt = 11'sd47;
          g_nxt = 11'sd52;
          b_nxt = 11'sd58;
        end else begin
          r_nxt = 11'sd94 + bs;
          g_nxt = 11'sd101 + bs;
          b_nxt = 11'sd108 + bs;
        end
      end
      KIND_BASKET: begin
        r_nxt = 11'sd174 + wl;
        g_nxt = 11'sd111 + chan_t'(div3(8'(wl <<< 1)));
        b_nxt = 11'sd47 + chan_t'(div3(8'(wl)));
      end
      default: begin
        r_nxt = 11'sd0;
        g_nxt = 11'sd0;
        b_nxt = 11'sd0;
      end
    endcase

    dark_nxt  = (in_ctl.kind == KIND_BURROW) && (m53 <= LIM53);
    light_nxt = (in_ctl.kind == KIND_BURROW) && !dark_nxt && (m79 <= LIM79);
  end

  always_comb begin
    ar = r7_r;
    ag = g7_r;
    ab = b7_r;
    if (dark7_r) begin
      ar = r7_r - 11'sd42;
      ag = g7_r - 11'sd32;
      ab = b7_r - 11'sd18;
    end else if (light7_r) begin
      ar = r7_r + 11'sd34;
      ag = g7_r + 11'sd26;
      ab = b7_r + 11'sd14;
    end
    shaded.r = clamp8(ar);
    shaded.g = clamp8(ag);
    shaded.b = clamp8(ab);

    case (ctl7_r.kind)
      KIND_FLOOR:  rgb_nxt = RGB_FLOOR;
      KIND_BURROW: rgb_nxt = ctl7_r.en ? shaded : RGB_BURROW;
      KIND_PANTRY: rgb_nxt = ctl7_r.en ? shaded : RGB_PANTRY;
      KIND_CELLAR: rgb_nxt = ctl7_r.en ? shaded : RGB_CELLAR;
      KIND_BASKET: rgb_nxt = ctl7_r.en ? shaded : RGB_BASKET;
      default:     rgb_nxt = RGB_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl7_r.valid <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      ctl7_r  <= in_ctl;
      valid_r <= ctl7_r.valid;
      if (ctl7_r.valid) begin
        rgb_r <= rgb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    r7_r     <= r_nxt;
    g7_r     <= g_nxt;
    b7_r     <= b_nxt;
    dark7_r  <= dark_nxt;
    light7_r <= light_nxt;
  end

  assign out_valid = valid_r;
  assign out_red   = rgb_r.r;
  assign out_green = rgb_r.g;
  assign out_blue  = rgb_r.b;

endmodule

// ===== hdl/ptws_check.sv =====
`timescale 1ns / 1ps
// ptws_check: port-level timing and fixed-color checks, bound to the top level
module ptws_check
  import ptws_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_tile_kind,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted beat produced no result strobe");

  a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without an accepted beat");

  a_floor_color: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_tile_kind == KIND_FLOOR) |-> ##PIPE_LAT
      (out_red == RGB_FLOOR.r && out_green == RGB_FLOOR.g && out_blue == RGB_FLOOR.b))
    else $error("floor tile color wrong");

  a_bad_kind_color: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_tile_kind > KIND_BASKET)) |-> ##PIPE_LAT
      (out_red == RGB_BAD.r && out_green == RGB_BAD.g && out_blue == RGB_BAD.b))
    else $error("unknown tile kind color wrong");

endmodule

bind procedural_wall_texel_sampler ptws_check u_ptws_check (.*);
